### design/aes_key_expansion_defines.svh
// ----------------------------------------------------------------------------
// aes key expansion assertion macros
// shared concurrent assertion shorthands for the key schedule block
// ----------------------------------------------------------------------------
`ifndef AES_KEY_EXPANSION_DEFINES_SVH
`define AES_KEY_EXPANSION_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AKE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define AKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/aes_ke_pkg.sv
// ----------------------------------------------------------------------------
// aes key expansion package
// shared types, key length codes and the aes s-box
// ----------------------------------------------------------------------------
package aes_ke_pkg;

  typedef logic [31:0] word_t;

  // key length codes, decoded by bit 1 first so code 3 acts as 256 bits
  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;

  localparam logic [7:0] RCON_FIRST = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### design/aes_ke_subword.sv
// ----------------------------------------------------------------------------
// aes key expansion subword unit
// byte-wise s-box substitution of one 32-bit word
// ----------------------------------------------------------------------------
module aes_ke_subword (
  input  aes_ke_pkg::word_t word_i,
  output aes_ke_pkg::word_t word_o
);

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      word_o[8*b +: 8] = aes_ke_pkg::sub_byte(word_i[8*b +: 8]);
    end
  end

endmodule

### design/aes_key_expansion.sv
// ----------------------------------------------------------------------------
// aes key expansion
// expands one 128/192/256-bit cipher key into its round keys, one word per
// cycle through a shared subword unit unless m_axis stalls, one round key per output beat
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                      beat contents
//  s_axis    in   tvalid tready tdata[255:0]   one cipher key
//  m_axis    out  tvalid tready tdata[127:0]   one round key, index, last flag
//                 tuser[3:0] tlast
//  cfg       in   cfg_we_i cfg_wdata_i[1:0]    key length code
//
//  one schedule word is made per cycle unless m_axis stalls, and four words make
//  a round key; a key occupies the block from its accept cycle to its last word,
//  as the word loop runs through the single subword unit
//  s_axis_tready is high whenever no key is being expanded; the last round
//  key may still sit in the output register while the next key is taken
//  a stalled m_axis holds the word loop only on the cycle that would finish
//  the next round key
//  reset clears the key length code to 128 bits and drops all valids
//
`include "aes_key_expansion_defines.svh"

module aes_key_expansion (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,     // key_length_mode
  // key input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,    // key_part_0, key_part_1, key_part_2, key_part_3
  // round key output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,    // round_key_high, round_key_low
  output logic [3:0]   m_axis_tuser,    // round_index
  output logic         m_axis_tlast     // last_key
);

  // key length register
  logic [1:0] mode_q;

  // sequencer state
  logic       busy_q;
  logic       load_q;          // still copying the cipher key words
  logic [2:0] phase_q;         // word index mod nk
  logic [1:0] pos_q;           // word position inside the round key
  logic [3:0] rnd_q;           // round key being built
  logic [7:0] rcon_q;
  logic [2:0] nkm1_q;          // nk - 1 for the key in flight
  logic [3:0] nr_q;            // last round index for the key in flight

  // key words and the sliding window of recent words (newest at 0)
  aes_ke_pkg::word_t key_q  [8];
  aes_ke_pkg::word_t hist_q [8];
  aes_ke_pkg::word_t gath_q [3];

  // output register
  logic         m_valid_q;
  logic [127:0] m_data_q;
  logic [3:0]   m_user_q;
  logic         m_last_q;

  logic [2:0] nkm1_d;
  logic [3:0] nr_d;
  logic       start;
  logic       finish;          // this word closes a round key
  logic       stall;
  logic       advance;
  logic       rot_sel;
  logic       sub_sel;
  aes_ke_pkg::word_t sub_in;
  aes_ke_pkg::word_t sub_out;
  aes_ke_pkg::word_t temp;
  aes_ke_pkg::word_t new_word;

  // key length decode, bit 1 wins so code 3 means 256 bits
  always_comb begin
    if (mode_q[1]) begin
      nkm1_d = 3'd7;
      nr_d   = 4'd14;
    end else if (mode_q == aes_ke_pkg::MODE_192) begin
      nkm1_d = 3'd5;
      nr_d   = 4'd12;
    end else begin
      nkm1_d = 3'd3;
      nr_d   = 4'd10;
    end
  end

  assign s_axis_tready = !busy_q;
  assign start         = s_axis_tvalid && !busy_q;
  assign finish        = (pos_q == 2'd3);
  assign stall         = finish && m_valid_q && !m_axis_tready;
  assign advance       = busy_q && !stall;

  // word rule: rotate+sub+rcon at the start of each nk group,
  // plain sub halfway through a 256-bit group
  assign rot_sel = !load_q && (phase_q == 3'd0);
  assign sub_sel = !load_q && (nkm1_q == 3'd7) && (phase_q == 3'd4);
  assign sub_in  = rot_sel ? {hist_q[0][23:0], hist_q[0][31:24]} : hist_q[0];

  aes_ke_subword u_subword (
    .word_i (sub_in),
    .word_o (sub_out)
  );

  always_comb begin
    if (rot_sel) begin
      temp = sub_out ^ {rcon_q, 24'h000000};
    end else if (sub_sel) begin
      temp = sub_out;
    end else begin
      temp = hist_q[0];
    end
    new_word = load_q ? key_q[phase_q] : (hist_q[nkm1_q] ^ temp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= aes_ke_pkg::MODE_128;
      busy_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      // a new round key replaces the beat taken on this edge
      if (advance && finish) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (start) begin
        busy_q <= 1'b1;
      end else if (advance && finish && (rnd_q == nr_q)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath and counters, qualified by busy so no reset is needed
  always_ff @(posedge clk_i) begin
    if (start) begin
      for (int k = 0; k < 8; k++) begin
        key_q[k] <= s_axis_tdata[64*(k/2) + 32*(1 - (k%2)) +: 32];
      end
      load_q  <= 1'b1;
      phase_q <= 3'd0;
      pos_q   <= 2'd0;
      rnd_q   <= 4'd0;
      rcon_q  <= aes_ke_pkg::RCON_FIRST;
      nkm1_q  <= nkm1_d;
      nr_q    <= nr_d;
    end else if (advance) begin
      hist_q[0] <= new_word;
      for (int k = 1; k < 8; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
      if (!finish) begin
        gath_q[pos_q] <= new_word;
      end
      pos_q <= pos_q + 2'd1;
      if (phase_q == nkm1_q) begin
        phase_q <= 3'd0;
        load_q  <= 1'b0;
      end else begin
        phase_q <= phase_q + 3'd1;
      end
      if (rot_sel) begin
        rcon_q <= aes_ke_pkg::xtime(rcon_q);
      end
      if (finish) begin
        rnd_q    <= rnd_q + 4'd1;
        m_data_q <= {gath_q[2], new_word, gath_q[0], gath_q[1]};
        m_user_q <= rnd_q;
        m_last_q <= (rnd_q == nr_q);
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // group counter never runs past the key length
  `AKE_ASSERT_NOW(a_phase_range, clk_i, rst_ni, busy_q, phase_q <= nkm1_q, "phase past nk")
  // rcon must not move while the cipher key words are copied
  `AKE_ASSERT_NOW(a_rcon_load, clk_i, rst_ni, busy_q && load_q, rcon_q == aes_ke_pkg::RCON_FIRST,
    "rcon advanced during key load")
  // a held output beat freezes the word loop
  `AKE_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stall && !start, $stable(rnd_q) && $stable(pos_q),
    "word loop moved under output stall")
  // the busy window ends only on the final round key
  `AKE_ASSERT_NEXT(a_done_last, clk_i, rst_ni, busy_q && advance && finish && rnd_q == nr_q,
    !busy_q && m_axis_tvalid && m_axis_tlast, "expansion ended without last beat")

endmodule

### test/aes_key_expansion_tb.sv
// ----------------------------------------------------------------------------
// aes key expansion testbench
// streams cipher keys of every length through the key schedule block and
// checks each round key beat against a schedule computed in the bench, with
// bursty key traffic, a stalling round key sink and key length changes
// ----------------------------------------------------------------------------
module aes_key_expansion_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // code 3 is decoded by bit 1 and must behave as a 256-bit key
  localparam logic [1:0] MODE_256_ALT = 2'd3;

  localparam int SETTLE_CYCLES   = 8;     // quiet time before a key length write
  localparam int TAIL_CYCLES     = 80;    // more than one 256-bit key worth of cycles
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles without any beat or write
  localparam int HOLD_MARK       = 1500;  // round key beats before the long sink stall
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_MARK      = 300;   // keys sent before the sender waits for a drain
  localparam int RANDOM_PHASES   = 10;
  localparam int KEYS_PER_PHASE  = 45;
  localparam int MAX_PRINTED     = 30;

  typedef struct packed {
    logic [3:0]  index;
    logic [63:0] high;
    logic [63:0] low;
    logic        last;
  } round_key_t;

  // dut ports, the inputs driven to known values from time zero
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_wdata_i = aes_ke_pkg::MODE_128;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // bench state
  logic [7:0]   sbox_lut [256];
  logic [1:0]   key_mode = aes_ke_pkg::MODE_128;   // bench copy of the key length register
  logic [255:0] keys_to_send [$];
  round_key_t   round_keys_due [$];
  int           keys_sent = 0;
  int           keys_by_len [3] = '{0, 0, 0};
  int           beats_checked = 0;
  int           error_count = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  logic         load_next;
  int           pattern_cnt = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  logic         drain_done = 1'b0;

  aes_key_expansion u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // schedule prediction
  // ---------------------------------------------------------------------------

  // product in gf(2^8) with the aes polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // s-box built from its definition: inverse (a^254) then the affine map
  function automatic void build_sbox();
    logic [7:0] inv;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(v));
      if (v == 0) inv = 8'h00;
      sbox_lut[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                  ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  endfunction

  function automatic aes_ke_pkg::word_t sbox_word(input aes_ke_pkg::word_t w);
    return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
  endfunction

  // expand one key under the given length code and queue its round keys
  function automatic void expand_key(input logic [1:0] mode, input logic [255:0] key);
    aes_ke_pkg::word_t w [60];
    aes_ke_pkg::word_t t;
    logic [7:0] rc;
    logic [63:0] part;
    int         nk;
    int         nr;
    round_key_t rk;
    if (mode[1]) begin
      nk = 8;
      nr = 14;
    end else if (mode == aes_ke_pkg::MODE_192) begin
      nk = 6;
      nr = 12;
    end else begin
      nk = 4;
      nr = 10;
    end
    keys_by_len[(nk - 4) / 2]++;
    rc = aes_ke_pkg::RCON_FIRST;
    // part k sits at tdata[64k +: 64], upper half is the earlier word
    for (int i = 0; i < nk; i++) begin
      part = key[64 * (i / 2) +: 64];
      w[i] = (i % 2) ? part[31:0] : part[63:32];
    end
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = w[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (nk == 8 && i % nk == 4) begin
        t = sbox_word(t);
      end
      w[i] = w[i - nk] ^ t;
    end
    for (int r = 0; r <= nr; r++) begin
      rk.index = 4'(r);
      rk.high  = {w[4 * r], w[4 * r + 1]};
      rk.low   = {w[4 * r + 2], w[4 * r + 3]};
      rk.last  = (r == nr);
      round_keys_due.push_back(rk);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // key sender: bursts of random length, random gaps, one pause for a drain
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      // predict on acceptance, under the length code now in force
      if (s_axis_tvalid && s_axis_tready) begin
        expand_key(key_mode, s_axis_tdata);
        keys_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        load_next = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (keys_sent == DRAIN_MARK && !drain_done) begin
          // hold the next key until every round key so far has come out
          if (round_keys_due.size() == 0) drain_done = 1'b1;
        end else if (keys_to_send.size() != 0) begin
          s_axis_tdata <= keys_to_send.pop_front();
          load_next = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // a long stretch with no gaps at all
            burst_left = $urandom_range(20, 40);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(0, 8);
            gap_left = $urandom_range(1, 30);
          end
        end
        s_axis_tvalid <= load_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // round key sink: a rotating stall pattern plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      pattern_cnt = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      pattern_cnt++;
      if (!hold_done && beats_checked >= HOLD_MARK) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        // segments in turn: always ready, coin flip, mostly ready, mostly stalled
        case ((pattern_cnt / 64) % 4)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1);
          2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // round key checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    round_key_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_checked++;
      if (round_keys_due.size() == 0) begin
        report_mismatch("unexpected round key beat", m_axis_tdata[63:0], '0);
      end else begin
        want = round_keys_due.pop_front();
        if (m_axis_tuser !== want.index)
          report_mismatch("round index", 64'(m_axis_tuser), 64'(want.index));
        if (m_axis_tdata[63:0] !== want.high)
          report_mismatch("round key high", m_axis_tdata[63:0], want.high);
        if (m_axis_tdata[127:64] !== want.low)
          report_mismatch("round key low", m_axis_tdata[127:64], want.low);
        if (m_axis_tlast !== want.last)
          report_mismatch("last key flag", 64'(m_axis_tlast), 64'(want.last));
      end
    end
  end

  // watchdog: any beat or register write restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d round keys outstanding",
                 WATCHDOG_LIMIT, round_keys_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // part 0 is the most significant key part and travels in the lowest bits
  function automatic logic [255:0] pack_key(input logic [63:0] p0, input logic [63:0] p1,
                                            input logic [63:0] p2, input logic [63:0] p3);
    return {p3, p2, p1, p0};
  endfunction

  function automatic logic [63:0] rand_part();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'(1) << $urandom_range(0, 63);
      3:       return ~(64'(1) << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // block is idle: nothing queued, nothing offered, no round key owed
  task automatic wait_idle();
    @(negedge clk_i);
    while (keys_to_send.size() != 0 || s_axis_tvalid || round_keys_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_key_length(input logic [1:0] code);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    key_mode = code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // corner keys: all zero, all one, byte ramp, alternating bits, unused parts opposite to used ones
  task automatic queue_corner_keys(input int count);
    logic [255:0] corners [5];
    corners[0] = '0;
    corners[1] = '1;
    corners[2] = pack_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                          64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    corners[3] = pack_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, '1, '1);
    corners[4] = pack_key('1, '1, '0, '0);
    for (int k = 0; k < count; k++) keys_to_send.push_back(corners[k]);
  endtask

  initial begin
    logic [1:0] code;
    build_sbox();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset length first, then every code written, extremes included
    queue_corner_keys(5);
    set_key_length(aes_ke_pkg::MODE_192);
    queue_corner_keys(4);
    set_key_length(aes_ke_pkg::MODE_256);
    queue_corner_keys(4);
    set_key_length(MODE_256_ALT);
    queue_corner_keys(3);
    set_key_length(aes_ke_pkg::MODE_128);
    queue_corner_keys(3);

    // random keys in phases, each under its own length code
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0)      code = aes_ke_pkg::MODE_128;
      else if (ph == 1) code = MODE_256_ALT;
      else if (ph == 2) code = aes_ke_pkg::MODE_192;
      else              code = 2'($urandom_range(0, 3));
      set_key_length(code);
      for (int k = 0; k < KEYS_PER_PHASE; k++)
        keys_to_send.push_back(pack_key(rand_part(), rand_part(), rand_part(), rand_part()));
    end

    // drain, then let the block settle; watchdog bounds the wait
    @(negedge clk_i);
    while (keys_to_send.size() != 0 || s_axis_tvalid || round_keys_due.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d keys (128-bit %0d, 192-bit %0d, 256-bit %0d)",
             keys_sent, keys_by_len[0], keys_by_len[1], keys_by_len[2]);
    $display("%0d round key beats checked, %0d mismatches", beats_checked, error_count);
    if (error_count == 0 && round_keys_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
